>>> hw/rtl/lrast_pkg.sv
package lrast_pkg;

  localparam logic [1:0] MODE_ASSIGN = 2'd0;
  localparam logic [1:0] MODE_ADD    = 2'd1;
  localparam logic [1:0] MODE_QUERY  = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_LOAD,
    OP_PF_INIT,
    OP_RD,
    OP_ACC,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_PF_FIN,
    OP_DELTA,
    OP_UP_INIT,
    OP_WR
  } op_t;

  typedef struct packed {
    op_t  op;
    logic second;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic       skip;
    logic [1:0] mode;
    logic       clr_last;
    logic       pf_end;
    logic       up_end;
  } stat_t;

endpackage

>>> hw/rtl/lazy_range_add_sum_tree_top.sv
// Completion: a query raises done once its sum is ready; a range add or point assign
// ends by dropping busy without raising done.
// Each index-tree step is a read state followed by an accumulate or write state.
// Throughput: one transaction at a time; busy falls in the cycle after done.
// Reset: synchronous; afterwards a clearing pass that zeroes all NUM_ELEMS entries of both trees holds busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
module lazy_range_add_sum_tree_top import lrast_pkg::*; #(
  parameter int NUM_ELEMS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode,
  input  logic [9:0]         lo_index,
  input  logic [9:0]         hi_index,
  input  logic signed [31:0] value,
  output logic               done,
  output logic signed [63:0] range_sum
);

  cmd_t        cmd_raw;
  cmd_t        cmd;
  stat_t       stat;
  logic [63:0] sum_bits;

  lrast_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd_raw),
    .busy  (busy),
    .done  (done)
  );

  always_comb begin
    cmd = cmd_raw;
  end

  lrast_dp #(.NUM_ELEMS(NUM_ELEMS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .mode      (mode),
    .lo_index  (lo_index),
    .hi_index  (hi_index),
    .value     (value),
    .stat      (stat),
    .range_sum (sum_bits)
  );

  assign range_sum = signed'(sum_bits);

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe while idle");

endmodule

>>> hw/rtl/lrast_mul.sv
module lrast_mul import lrast_pkg::*; #(
  parameter int IW = 12
) (
  input  logic          clk,
  input  logic [63:0]   a,
  input  logic [IW-1:0] b,
  input  logic          step_lo,
  input  logic          step_hi,
  output logic [63:0]   prod
);

  logic [32+IW-1:0] plo;
  logic [31:0]      phi;
  logic [32+IW-1:0] t_hi;

  assign t_hi = a[63:32] * b;

  always_ff @(posedge clk) begin
    if (step_lo) begin
      plo <= a[31:0] * b;
    end
    if (step_hi) begin
      phi <= t_hi[31:0];
    end
  end

  assign prod = 64'(plo) + {phi, 32'b0};

endmodule

>>> hw/rtl/lrast_dp.sv
module lrast_dp import lrast_pkg::*; #(
  parameter int NUM_ELEMS = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic [1:0]         mode,
  input  logic [9:0]         lo_index,
  input  logic [9:0]         hi_index,
  input  logic signed [31:0] value,
  output stat_t              stat,
  output logic [63:0]        range_sum
);

  localparam int AW = (NUM_ELEMS > 1) ? $clog2(NUM_ELEMS) : 1;
  localparam int IW = $clog2(NUM_ELEMS) + 2;

  logic [63:0] tree1 [NUM_ELEMS];
  logic [63:0] tree2 [NUM_ELEMS];

  logic [1:0]    mode_r;
  logic          skip_r;
  logic [IW-1:0] lo_r;
  logic [IW-1:0] hc_r;
  logic [IW-1:0] i_r;
  logic [IW-1:0] px_r;
  logic [63:0]   val_r;
  logic [63:0]   s1;
  logic [63:0]   s2;
  logic [63:0]   pa;
  logic [63:0]   res_r;
  logic [63:0]   d1;
  logic [63:0]   d2;
  logic [63:0]   rd1;
  logic [63:0]   rd2;
  logic [AW-1:0] clr_addr;

  logic [31:0]   lo32;
  logic [31:0]   hi32;
  logic [31:0]   hclip32;
  logic [IW-1:0] lowbit;
  logic [IW-1:0] im1;
  logic [63:0]   mul_a;
  logic [IW-1:0] mul_b;
  logic [63:0]   prod;
  logic [63:0]   pfx;
  logic          we;
  logic [AW-1:0] waddr;
  logic [63:0]   wd1;
  logic [63:0]   wd2;

  assign lo32    = 32'(lo_index);
  assign hi32    = 32'(hi_index);
  assign hclip32 = (hi32 >= 32'(NUM_ELEMS)) ? 32'(NUM_ELEMS - 1) : hi32;
  assign lowbit  = i_r & (~i_r + IW'(1));
  assign im1     = i_r - IW'(1);

  always_comb begin
    if (cmd.upd) begin
      mul_a = cmd.second ? (64'd0 - val_r) : val_r;
      mul_b = cmd.second ? (hc_r + IW'(1)) : lo_r;
    end else begin
      mul_a = s1;
      mul_b = px_r;
    end
  end

  lrast_mul #(.IW(IW)) u_mul (
    .clk     (clk),
    .a       (mul_a),
    .b       (mul_b),
    .step_lo (cmd.op == OP_MUL_LO),
    .step_hi (cmd.op == OP_MUL_HI),
    .prod    (prod)
  );

  assign pfx = prod - s2;

  assign we    = (cmd.op == OP_CLR) || (cmd.op == OP_WR);
  assign waddr = (cmd.op == OP_CLR) ? clr_addr : im1[AW-1:0];
  assign wd1   = (cmd.op == OP_CLR) ? 64'd0 : rd1 + d1;
  assign wd2   = (cmd.op == OP_CLR) ? 64'd0 : rd2 + d2;

  always_ff @(posedge clk) begin
    if (we) begin
      tree1[waddr] <= wd1;
      tree2[waddr] <= wd2;
    end
    rd1 <= tree1[im1[AW-1:0]];
    rd2 <= tree2[im1[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.op == OP_CLR) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        mode_r <= mode;
        lo_r   <= IW'(lo32);
        val_r  <= 64'(signed'(value));
        res_r  <= 64'd0;
        if (mode == MODE_ASSIGN) begin
          hc_r   <= IW'(lo32);
          skip_r <= lo32 >= 32'(NUM_ELEMS);
        end else begin
          hc_r   <= IW'(hclip32);
          skip_r <= (mode != MODE_ADD && mode != MODE_QUERY) || (lo32 > hclip32);
        end
      end
      OP_PF_INIT: begin
        i_r  <= cmd.second ? lo_r : hc_r + IW'(1);
        px_r <= cmd.second ? lo_r : hc_r + IW'(1);
        s1   <= 64'd0;
        s2   <= 64'd0;
      end
      OP_ACC: begin
        s1  <= s1 + rd1;
        s2  <= s2 + rd2;
        i_r <= i_r - lowbit;
      end
      OP_PF_FIN: begin
        if (cmd.second) begin
          res_r <= pa - pfx;
        end else begin
          pa <= pfx;
        end
      end
      OP_DELTA: begin
        val_r <= val_r - res_r;
      end
      OP_UP_INIT: begin
        i_r <= cmd.second ? hc_r + IW'(2) : lo_r + IW'(1);
        d1  <= cmd.second ? (64'd0 - val_r) : val_r;
        d2  <= prod;
      end
      OP_WR: begin
        i_r <= i_r + lowbit;
      end
      default: begin
      end
    endcase
  end

  assign stat.skip     = skip_r;
  assign stat.mode     = mode_r;
  assign stat.clr_last = clr_addr == AW'(NUM_ELEMS - 1);
  assign stat.pf_end   = i_r == '0;
  assign stat.up_end   = (i_r == '0) || (i_r > IW'(NUM_ELEMS));
  assign range_sum     = res_r;

endmodule

>>> hw/rtl/lrast_ctrl.sv
module lrast_ctrl import lrast_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  done
);

  typedef enum logic [15:0] {
    ST_CLEAR   = 16'b0000000000000001,
    ST_IDLE    = 16'b0000000000000010,
    ST_CHECK   = 16'b0000000000000100,
    ST_PF_INIT = 16'b0000000000001000,
    ST_PF_TEST = 16'b0000000000010000,
    ST_PF_ACC  = 16'b0000000000100000,
    ST_PF_M1   = 16'b0000000001000000,
    ST_PF_M2   = 16'b0000000010000000,
    ST_PF_FIN  = 16'b0000000100000000,
    ST_DELTA   = 16'b0000001000000000,
    ST_UP_M1   = 16'b0000010000000000,
    ST_UP_M2   = 16'b0000100000000000,
    ST_UP_INIT = 16'b0001000000000000,
    ST_UP_TEST = 16'b0010000000000000,
    ST_UP_WR   = 16'b0100000000000000,
    ST_DONE    = 16'b1000000000000000
  } state_t;

  state_t state, state_next;
  logic   sec, sec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      sec   <= 1'b0;
    end else begin
      state <= state_next;
      sec   <= sec_next;
    end
  end

  always_comb begin
    state_next = state;
    sec_next   = sec;
    cmd.op     = OP_NONE;
    cmd.second = sec;
    cmd.upd    = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd.op     = OP_LOAD;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        sec_next = 1'b0;
        if (stat.skip) begin
          state_next = (stat.mode == MODE_QUERY) ? ST_DONE : ST_IDLE;
        end else if (stat.mode == MODE_ADD) begin
          state_next = ST_UP_M1;
        end else begin
          state_next = ST_PF_INIT;
        end
      end
      ST_PF_INIT: begin
        cmd.op     = OP_PF_INIT;
        state_next = ST_PF_TEST;
      end
      ST_PF_TEST: begin
        if (stat.pf_end) begin
          state_next = ST_PF_M1;
        end else begin
          cmd.op     = OP_RD;
          state_next = ST_PF_ACC;
        end
      end
      ST_PF_ACC: begin
        cmd.op     = OP_ACC;
        state_next = ST_PF_TEST;
      end
      ST_PF_M1: begin
        cmd.op     = OP_MUL_LO;
        state_next = ST_PF_M2;
      end
      ST_PF_M2: begin
        cmd.op     = OP_MUL_HI;
        state_next = ST_PF_FIN;
      end
      ST_PF_FIN: begin
        cmd.op = OP_PF_FIN;
        if (!sec) begin
          sec_next   = 1'b1;
          state_next = ST_PF_INIT;
        end else begin
          sec_next   = 1'b0;
          state_next = (stat.mode == MODE_QUERY) ? ST_DONE : ST_DELTA;
        end
      end
      ST_DELTA: begin
        cmd.op     = OP_DELTA;
        state_next = ST_UP_M1;
      end
      ST_UP_M1: begin
        cmd.op     = OP_MUL_LO;
        cmd.upd    = 1'b1;
        state_next = ST_UP_M2;
      end
      ST_UP_M2: begin
        cmd.op     = OP_MUL_HI;
        cmd.upd    = 1'b1;
        state_next = ST_UP_INIT;
      end
      ST_UP_INIT: begin
        cmd.op     = OP_UP_INIT;
        state_next = ST_UP_TEST;
      end
      ST_UP_TEST: begin
        if (stat.up_end) begin
          if (!sec) begin
            sec_next   = 1'b1;
            state_next = ST_UP_M1;
          end else begin
            sec_next   = 1'b0;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.op     = OP_RD;
          state_next = ST_UP_WR;
        end
      end
      ST_UP_WR: begin
        cmd.op     = OP_WR;
        state_next = ST_UP_TEST;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = state != ST_IDLE;
  assign done = state == ST_DONE;

endmodule
